@@ sv/pmt_pkg.sv @@
package pmt_pkg;

  localparam int CoordBitsDef = 12;
  localparam int SizeW        = 13;
  localparam int CfgIdxW      = 4;

  localparam int ResetX         = 160;
  localparam int ResetY         = 100;
  localparam int ScreenWidthRst = 320;
  localparam int ScreenHeightRst = 200;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = CfgIdxW'(1);

  // result kinds
  localparam logic KindKey   = 1'b0;
  localparam logic KindMouse = 1'b1;

  // header bit positions
  localparam int HdrLeft   = 0;
  localparam int HdrRight  = 1;
  localparam int HdrMiddle = 2;
  localparam int HdrSync   = 3;
  localparam int HdrXSign  = 4;
  localparam int HdrYSign  = 5;
  localparam int HdrXOvf   = 6;
  localparam int HdrYOvf   = 7;

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhXMove  = 2'd1,
    PhYMove  = 2'd2
  } phase_e;

endpackage

@@ sv/pmt_in_if.sv @@
interface pmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       from_aux;

  modport source (output valid, output rx_byte, output from_aux, input ready);
  modport sink   (input valid, input rx_byte, input from_aux, output ready);
endinterface

@@ sv/pmt_out_if.sv @@
interface pmt_out_if #(
  parameter int CoordBits = pmt_pkg::CoordBitsDef
);
  logic                 valid;
  logic                 ready;
  logic                 result_kind;
  logic [7:0]           key_byte;
  logic [CoordBits-1:0] pos_x;
  logic [CoordBits-1:0] pos_y;
  logic                 button_left;
  logic                 button_right;
  logic                 button_middle;

  modport source (
    output valid, output result_kind, output key_byte, output pos_x, output pos_y,
    output button_left, output button_right, output button_middle, input ready
  );
  modport sink (
    input valid, input result_kind, input key_byte, input pos_x, input pos_y,
    input button_left, input button_right, input button_middle, output ready
  );
endinterface

@@ sv/pmt_cfg_if.sv @@
interface pmt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pmt_pkg::CfgIdxW-1:0]  index;
  logic [pmt_pkg::SizeW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/ps2_mouse_packet_tracker_core.sv @@
// PS/2 byte tracker: takes one controller byte per cycle. Keyboard bytes come
// out as a result at once; mouse bytes build three-byte packets (header needs
// bit 3 set) and the third byte yields a result with the saturated cursor and
// the buttons. A result shows in the cycle after its byte; the single result
// register lets a new byte in every cycle as long as the sink takes results.
// Screen size registers may only be written while no byte is in flight.
module ps2_mouse_packet_tracker_core #(
  parameter int CoordBits = pmt_pkg::CoordBitsDef
) (
  input logic         clk_i,
  input logic         rst_ni,
  pmt_in_if.sink      in_i,
  pmt_out_if.source   out_o,
  pmt_cfg_if.sink     cfg_i
);

  localparam int SumW = CoordBits + 2;
  localparam int LimW = (CoordBits > pmt_pkg::SizeW) ? CoordBits : pmt_pkg::SizeW;
  localparam logic [LimW-1:0] CoordMax = LimW'((1 << CoordBits) - 1);

  logic [pmt_pkg::SizeW-1:0] width_q, height_q;

  pmt_pkg::phase_e phase_q, phase_d;
  logic [7:0]           header_q, header_d;
  logic [7:0]           xmove_q, xmove_d;
  logic [CoordBits-1:0] cur_x_q, cur_x_d;
  logic [CoordBits-1:0] cur_y_q, cur_y_d;

  logic                 out_valid_q;
  logic                 kind_q;
  logic [7:0]           key_q;
  logic [CoordBits-1:0] pos_x_q, pos_y_q;
  logic                 btn_l_q, btn_r_q, btn_m_q;

  logic in_fire, res_fire, pkt_done;

  logic signed [8:0]      dx, dy;
  logic signed [SumW-1:0] sum_x, sum_y;
  logic [CoordBits-1:0]   lim_x, lim_y, sat_x, sat_y;

  function automatic logic [CoordBits-1:0] coord_limit(logic [pmt_pkg::SizeW-1:0] size);
    logic [pmt_pkg::SizeW-1:0] m1;
    logic [CoordBits-1:0]      lim;
    m1 = size - pmt_pkg::SizeW'(1);
    if (size == '0) begin
      lim = '0;
    end else if (LimW'(m1) > CoordMax) begin
      lim = CoordMax[CoordBits-1:0];
    end else begin
      lim = CoordBits'(m1);
    end
    return lim;
  endfunction

  function automatic logic [CoordBits-1:0] saturate(logic signed [SumW-1:0] v,
                                                    logic [CoordBits-1:0] lim);
    logic [CoordBits-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v[CoordBits:0] > {1'b0, lim}) begin
      r = lim;
    end else begin
      r = v[CoordBits-1:0];
    end
    return r;
  endfunction

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;

  // movement: 9-bit two's complement, zero when the overflow bit is set
  always_comb begin
    dx = header_q[pmt_pkg::HdrXOvf] ? 9'sd0
                                    : $signed({header_q[pmt_pkg::HdrXSign], xmove_q});
    dy = header_q[pmt_pkg::HdrYOvf] ? 9'sd0
                                    : $signed({header_q[pmt_pkg::HdrYSign], in_i.rx_byte});
    sum_x = $signed({2'b00, cur_x_q}) + SumW'(dx);
    sum_y = $signed({2'b00, cur_y_q}) - SumW'(dy);
    lim_x = coord_limit(width_q);
    lim_y = coord_limit(height_q);
    sat_x = saturate(sum_x, lim_x);
    sat_y = saturate(sum_y, lim_y);
  end

  always_comb begin
    phase_d  = phase_q;
    header_d = header_q;
    xmove_d  = xmove_q;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    pkt_done = 1'b0;
    if (in_fire && in_i.from_aux) begin
      case (phase_q)
        pmt_pkg::PhXMove: begin
          xmove_d = in_i.rx_byte;
          phase_d = pmt_pkg::PhYMove;
        end
        pmt_pkg::PhYMove: begin
          phase_d  = pmt_pkg::PhHeader;
          cur_x_d  = sat_x;
          cur_y_d  = sat_y;
          pkt_done = 1'b1;
        end
        default: begin
          if (in_i.rx_byte[pmt_pkg::HdrSync]) begin
            header_d = in_i.rx_byte;
            phase_d  = pmt_pkg::PhXMove;
          end else begin
            phase_d = pmt_pkg::PhHeader;
          end
        end
      endcase
    end
  end

  assign res_fire = in_fire && (!in_i.from_aux || pkt_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= pmt_pkg::SizeW'(pmt_pkg::ScreenWidthRst);
      height_q    <= pmt_pkg::SizeW'(pmt_pkg::ScreenHeightRst);
      phase_q     <= pmt_pkg::PhHeader;
      header_q    <= '0;
      xmove_q     <= '0;
      cur_x_q     <= CoordBits'(pmt_pkg::ResetX);
      cur_y_q     <= CoordBits'(pmt_pkg::ResetY);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          pmt_pkg::CfgScreenWidth:  width_q  <= cfg_i.data;
          pmt_pkg::CfgScreenHeight: height_q <= cfg_i.data;
          default: ;
        endcase
      end
      phase_q  <= phase_d;
      header_q <= header_d;
      xmove_q  <= xmove_d;
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      if (!in_i.from_aux) begin
        kind_q  <= pmt_pkg::KindKey;
        key_q   <= in_i.rx_byte;
        pos_x_q <= '0;
        pos_y_q <= '0;
        btn_l_q <= 1'b0;
        btn_r_q <= 1'b0;
        btn_m_q <= 1'b0;
      end else begin
        kind_q  <= pmt_pkg::KindMouse;
        key_q   <= '0;
        pos_x_q <= sat_x;
        pos_y_q <= sat_y;
        btn_l_q <= header_q[pmt_pkg::HdrLeft];
        btn_r_q <= header_q[pmt_pkg::HdrRight];
        btn_m_q <= header_q[pmt_pkg::HdrMiddle];
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = kind_q;
  assign out_o.key_byte      = key_q;
  assign out_o.pos_x         = pos_x_q;
  assign out_o.pos_y         = pos_y_q;
  assign out_o.button_left   = btn_l_q;
  assign out_o.button_right  = btn_r_q;
  assign out_o.button_middle = btn_m_q;

endmodule
